// ----- design/salwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_pkg
// shared types and constants for the write-back lru cache tag controller
// ----------------------------------------------------------------------------
package salwc_pkg;

  localparam int unsigned DefSets       = 64;
  localparam int unsigned DefWays       = 4;
  localparam int unsigned DefBlockBytes = 32;
  localparam int unsigned AddrBits      = 32;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way_used;
    logic        fetch_request;
    logic        writeback_valid;
    logic [31:0] writeback_address;
  } rsp_t;

endpackage

// ----- design/salwc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_fifo
// two-entry request queue between the front end and the tag engine
// ----------------------------------------------------------------------------
module salwc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  salwc_pkg::req_t   push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output salwc_pkg::req_t   pop_data
);

  salwc_pkg::req_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ----- design/salwc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salwc_engine
// tag lookup, victim choice, lru update and result register; each set's
// ways live in one ram line, read as a request is taken and rewritten
// with the result, after a clearing pass over all lines that follows reset
// ----------------------------------------------------------------------------
module salwc_engine #(
  parameter int unsigned SETS        = salwc_pkg::DefSets,
  parameter int unsigned WAYS        = salwc_pkg::DefWays,
  parameter int unsigned BLOCK_BYTES = salwc_pkg::DefBlockBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_avail,
  input  salwc_pkg::req_t req,
  output logic            req_take,
  output logic            out_valid,
  input  logic            out_stall,
  output salwc_pkg::rsp_t out_data
);

  localparam int unsigned OffBits = $clog2(BLOCK_BYTES);
  localparam int unsigned SetBitsRaw = $clog2(SETS);
  localparam int unsigned SetBits = (SetBitsRaw == 0) ? 1 : SetBitsRaw;
  localparam int unsigned SetWide = SetBits + 1;
  localparam int unsigned LowBits = OffBits + SetBitsRaw;
  localparam int unsigned TagBits = salwc_pkg::AddrBits - LowBits;
  localparam int unsigned AgeBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WayBits = AgeBits;

  typedef struct packed {
    logic [TagBits-1:0] tag;
    logic               vld;
    logic               drt;
    logic [AgeBits-1:0] age;
  } way_t;

  typedef way_t [WAYS-1:0] line_t;

  typedef enum logic [1:0] {StClear, StIdle, StLook} state_t;

  state_t             state;
  logic [SetBits-1:0] clr_idx;
  logic [SetBits-1:0] cur_set;
  logic [TagBits-1:0] cur_tag;
  logic               cur_write;

  logic [SetBits-1:0] req_set;
  logic [TagBits-1:0] req_tag;
  logic               can_finish;
  logic               ram_wr_en;
  logic [SetBits-1:0] ram_wr_addr;
  line_t              ram_wr_data;
  line_t              rd_line;
  line_t              line_next;
  line_t              init_line;
  logic               hit;
  logic [WayBits-1:0] way;
  logic               wb;
  logic [31:0]        wb_addr;
  logic [AgeBits-1:0] old_age;
  logic [AgeBits-1:0] max_age;

  always_comb begin
    logic [SetBits-1:0] raw;
    raw = '0;
    if (SetBitsRaw > 0) raw = SetBits'(req.address >> OffBits);
    req_set = raw;
    if ({1'b0, raw} >= SetWide'(SETS)) req_set = raw - SetBits'(SETS);
    req_tag = TagBits'(req.address >> LowBits);
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      init_line[w].tag = '0;
      init_line[w].vld = 1'b0;
      init_line[w].drt = 1'b0;
      init_line[w].age = AgeBits'(w);
    end
  end

  always_comb begin
    hit = 1'b0;
    way = '0;
    max_age = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_line[w].vld && rd_line[w].tag == cur_tag) begin
        hit = 1'b1;
        way = WayBits'(w);
      end
    end
    if (!hit && WAYS > 1) begin
      for (int w = 0; w < WAYS; w++) begin
        if (rd_line[w].age > max_age) begin
          max_age = rd_line[w].age;
          way = WayBits'(w);
        end
      end
    end
    wb = !hit && rd_line[way].vld && rd_line[way].drt;
    wb_addr = '0;
    if (wb) begin
      wb_addr = 32'({rd_line[way].tag, {LowBits{1'b0}}}) |
                (32'(cur_set) << OffBits);
    end
    old_age = rd_line[way].age;
    line_next = rd_line;
    if (hit) begin
      if (cur_write) line_next[way].drt = 1'b1;
    end else begin
      line_next[way].tag = cur_tag;
      line_next[way].vld = 1'b1;
      line_next[way].drt = cur_write;
    end
    if (WAYS > 1) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WayBits'(w) == way) line_next[w].age = '0;
        else if (rd_line[w].age < old_age)
          line_next[w].age = rd_line[w].age + AgeBits'(1);
      end
    end
  end

  assign can_finish  = !out_valid || !out_stall;
  assign req_take    = (state == StIdle) && req_avail;
  assign ram_wr_en   = (state == StClear) || ((state == StLook) && can_finish);
  assign ram_wr_addr = (state == StClear) ? clr_idx : cur_set;
  assign ram_wr_data = (state == StClear) ? init_line : line_next;

  salwc_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (req_take),
    .rd_addr (req_set),
    .rd_data (rd_line),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StClear;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        StClear: begin
          if (clr_idx == SetBits'(SETS - 1)) state <= StIdle;
          clr_idx <= clr_idx + SetBits'(1);
        end
        StIdle: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (req_avail) begin
            cur_set   <= req_set;
            cur_tag   <= req_tag;
            cur_write <= (req.opcode == salwc_pkg::OpWrite);
            state     <= StLook;
          end
        end
        StLook: begin
          if (can_finish) begin
            out_valid                  <= 1'b1;
            out_data.hit               <= hit;
            out_data.way_used          <= 2'(way);
            out_data.fetch_request     <= !hit;
            out_data.writeback_valid   <= wb;
            out_data.writeback_address <= wb_addr;
            state                      <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----------------------------------------------------------------------------
// salwc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module salwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data,
  input  logic                                     wr_en,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/set_assoc_lru_writeback_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// tag controller for a set-associative write-back write-allocate lru cache
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one access beat (opcode, address).
//   out_valid/out_stall/out_data carry one result beat per access.
//   a beat enters a two-entry queue; the tag engine takes one access at a
//   time, reads the set's line from ram, then checks tags, picks the
//   victim, rewrites tags/dirty/lru and registers the result.
//   each access passes through the engine's idle state, where the ram read
//   is issued, and its look state, where the result registers; the engine
//   takes no new access until the previous one has left the look state.
//   when out_stall is high the result register holds, the engine waits
//   with its next result, the queue fills and in_stall rises once two
//   accesses wait.
//   reset starts a clearing pass over all SETS lines (64 by default) that
//   clears tags, valid and dirty bits and sets way j's age to j; accesses
//   queue up meanwhile and the first one is taken when the pass ends.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
  parameter int unsigned SETS        = salwc_pkg::DefSets,
  parameter int unsigned WAYS        = salwc_pkg::DefWays,
  parameter int unsigned BLOCK_BYTES = salwc_pkg::DefBlockBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  salwc_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output salwc_pkg::rsp_t out_data
);

  logic            full;
  logic            empty;
  logic            take;
  salwc_pkg::req_t head;

  assign in_stall = full;

  salwc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (in_data),
    .full      (full),
    .pop       (take),
    .empty     (empty),
    .pop_data  (head)
  );

  salwc_engine #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_avail (!empty),
    .req       (head),
    .req_take  (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
